// ===== sv/kdc_pkg.sv =====
// ----------------------------------------------------------------------------
// kdc_pkg: shared types and constants of the key debounce / click detector
// Item formats, phase and event codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package kdc_pkg;

    // Key and sample geometry
    localparam int KEYS         = 8;
    localparam int KEY_W        = 3;
    localparam int SAMPLE_COUNT = 5;
    localparam int VOTE_W       = 3;
    localparam int TICK_W       = 17;
    localparam int TIME_W       = 32;

    localparam logic [TICK_W-1:0] TICK_MAX = 17'h1FFFF;

    // Vote thresholds over the five samples
    localparam logic [VOTE_W-1:0] VOTE_PRESS   = 3'd4;
    localparam logic [VOTE_W-1:0] VOTE_RELEASE = 3'd1;

    // Key phases
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_PDEB  = 3'd1;
    localparam logic [2:0] PH_PRESS = 3'd2;
    localparam logic [2:0] PH_RDEB  = 3'd3;
    localparam logic [2:0] PH_LONG  = 3'd4;

    // Latched events
    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_DOWN   = 3'd1;
    localparam logic [2:0] EV_LDOWN  = 3'd2;
    localparam logic [2:0] EV_UP     = 3'd3;
    localparam logic [2:0] EV_LUP    = 3'd4;
    localparam logic [2:0] EV_REPEAT = 3'd5;
    localparam logic [2:0] EV_CLICK  = 3'd6;
    localparam logic [2:0] EV_DCLICK = 3'd7;

    // Sample classes
    localparam logic [1:0] CLS_RELEASED = 2'd0;
    localparam logic [1:0] CLS_PRESSED  = 2'd1;
    localparam logic [1:0] CLS_BOUNCE   = 2'd2;

    // Click counter
    localparam logic [1:0] CLICK_ONE    = 2'd1;
    localparam logic [1:0] CLICK_DOUBLE = 2'd2;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_STEP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DC_WINDOW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_MASK  = 3'd6;

    // Register reset values
    localparam logic [7:0]  RST_SCAN_STEP  = 8'd5;
    localparam logic [15:0] RST_DEBOUNCE   = 16'd20;
    localparam logic [15:0] RST_LONG_PRESS = 16'd1000;
    localparam logic [15:0] RST_REPEAT     = 16'd200;
    localparam logic [15:0] RST_DC_WINDOW  = 16'd500;
    localparam logic [3:0]  RST_KEY_COUNT  = 4'd1;
    localparam logic [7:0]  RST_LEVEL_MASK = 8'd0;

    // One scan of one key
    typedef struct packed {
        logic [KEY_W-1:0]        key_select;
        logic [SAMPLE_COUNT-1:0] pin_samples;
        logic [TIME_W-1:0]       now_ms;
    } t_in_item;

    // One result
    typedef struct packed {
        logic [KEY_W-1:0] key_out;
        logic [2:0]       key_phase;
        logic [2:0]       key_event;
        logic [1:0]       sample_class;
    } t_out_item;

    // Classified scan between front and back
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [1:0]        cls;
        logic [TIME_W-1:0] now;
    } t_scan;

    // Configuration registers
    typedef struct packed {
        logic [7:0]  scan_step;
        logic [15:0] debounce_time;
        logic [15:0] long_press_time;
        logic [15:0] repeat_time;
        logic [15:0] dc_window;
        logic [3:0]  key_count;
        logic [7:0]  level_mask;
    } t_cfg;

endpackage

// ===== sv/kdc_fifo.sv =====
// ----------------------------------------------------------------------------
// kdc_fifo: small register queue
// Push and pop may happen in the same cycle; full and empty come from a count.
// ----------------------------------------------------------------------------
module kdc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== sv/kdc_front.sv =====
// ----------------------------------------------------------------------------
// kdc_front: scan intake and sample vote
// Compares the five samples with the key's active level, classifies the vote
// and queues the classified scan for the key state engine.
// ----------------------------------------------------------------------------
module kdc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  kdc_pkg::t_in_item i_item,
    input  logic [7:0]        i_level_mask,
    output kdc_pkg::t_scan    o_scan,
    output logic              o_scan_valid,
    input  logic              i_scan_take
);

    logic                                level;
    logic [kdc_pkg::SAMPLE_COUNT-1:0]    active;
    logic [kdc_pkg::VOTE_W-1:0]          votes;
    kdc_pkg::t_scan                      scan;
    logic                                q_empty;

    // Vote: a sample counts when it equals the key's pressed level
    always_comb begin
        level  = i_level_mask[i_item.key_select];
        active = ~(i_item.pin_samples ^ {kdc_pkg::SAMPLE_COUNT{level}});
        votes  = '0;
        for (int i = 0; i < kdc_pkg::SAMPLE_COUNT; i++) begin
            votes = votes + {2'b00, active[i]};
        end
    end

    // Classify
    always_comb begin
        scan.key = i_item.key_select;
        scan.now = i_item.now_ms;
        if (votes >= kdc_pkg::VOTE_PRESS) begin
            scan.cls = kdc_pkg::CLS_PRESSED;
        end else if (votes <= kdc_pkg::VOTE_RELEASE) begin
            scan.cls = kdc_pkg::CLS_RELEASED;
        end else begin
            scan.cls = kdc_pkg::CLS_BOUNCE;
        end
    end

    // Queue toward the state engine
    kdc_fifo #(
        .WIDTH ($bits(kdc_pkg::t_scan)),
        .DEPTH (2)
    ) u_scan_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (scan),
        .o_full  (o_full),
        .i_pop   (i_scan_take),
        .o_data  (o_scan),
        .o_empty (q_empty)
    );

    assign o_scan_valid = !q_empty;

endmodule

// ===== sv/kdc_back.sv =====
// ----------------------------------------------------------------------------
// kdc_back: per-key state engine
// Read-modify-write of one key's phase, tick, event and click state per scan,
// result queued toward the output.
// ----------------------------------------------------------------------------
module kdc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  kdc_pkg::t_scan     i_scan,
    input  logic               i_scan_valid,
    output logic               o_scan_take,
    input  kdc_pkg::t_cfg      i_cfg,
    output logic               o_empty,
    input  logic               i_pop,
    output kdc_pkg::t_out_item o_item
);

    localparam int KEYS   = kdc_pkg::KEYS;
    localparam int TICK_W = kdc_pkg::TICK_W;
    localparam int TIME_W = kdc_pkg::TIME_W;

    // Per-key state
    logic [2:0]        r_phase [KEYS];
    logic [2:0]        r_event [KEYS];
    logic [TICK_W-1:0] r_tick  [KEYS];
    logic [1:0]        r_click [KEYS];
    logic [TIME_W-1:0] r_last  [KEYS];

    logic [2:0]        n_phase, n_event;
    logic [TICK_W-1:0] n_tick;
    logic [1:0]        n_click;
    logic [TIME_W-1:0] n_last;

    logic [kdc_pkg::KEY_W-1:0] key;
    logic                      in_use, act, out_full;
    logic [2:0]                cur_phase, cur_event;
    logic [TICK_W-1:0]         cur_tick, tick_inc;
    logic [TICK_W:0]           tick_sum;
    logic [1:0]                cur_click, click_inc;
    logic [TIME_W-1:0]         since_release;
    logic                      in_window;
    kdc_pkg::t_out_item        result;

    assign key         = i_scan.key;
    assign act         = (i_scan.cls == kdc_pkg::CLS_PRESSED);
    assign in_use      = ({1'b0, key} < i_cfg.key_count);
    assign o_scan_take = i_scan_valid && !out_full;

    assign cur_phase = r_phase[key];
    assign cur_event = r_event[key];
    assign cur_tick  = r_tick[key];
    assign cur_click = r_click[key];

    // Saturating tick advance and release timing
    assign tick_sum      = {1'b0, cur_tick} + {{(TICK_W - 7){1'b0}}, i_cfg.scan_step};
    assign tick_inc      = tick_sum[TICK_W] ? kdc_pkg::TICK_MAX : tick_sum[TICK_W-1:0];
    assign since_release = i_scan.now - r_last[key];
    assign in_window     = (since_release < {16'h0000, i_cfg.dc_window});
    assign click_inc     = cur_click + 2'd1;

    // Phase machine
    always_comb begin
        n_phase = cur_phase;
        n_event = cur_event;
        n_tick  = cur_tick;
        n_click = cur_click;
        n_last  = r_last[key];
        case (cur_phase)
            kdc_pkg::PH_IDLE: begin
                if (act) begin
                    n_phase = kdc_pkg::PH_PDEB;
                    n_tick  = '0;
                end
            end
            kdc_pkg::PH_PDEB: begin
                if (act) begin
                    n_tick = tick_inc;
                    if (tick_inc >= {1'b0, i_cfg.debounce_time}) begin
                        n_phase = kdc_pkg::PH_PRESS;
                        n_event = kdc_pkg::EV_DOWN;
                        n_tick  = '0;
                    end
                end else begin
                    n_phase = kdc_pkg::PH_IDLE;
                end
            end
            kdc_pkg::PH_PRESS: begin
                if (act) begin
                    n_tick = tick_inc;
                    if (tick_inc >= {1'b0, i_cfg.long_press_time}) begin
                        n_phase = kdc_pkg::PH_LONG;
                        n_event = kdc_pkg::EV_LDOWN;
                        n_tick  = '0;
                    end
                end else begin
                    n_phase = kdc_pkg::PH_RDEB;
                    n_tick  = '0;
                end
            end
            kdc_pkg::PH_RDEB: begin
                if (!act) begin
                    n_tick = tick_inc;
                    if (tick_inc >= {1'b0, i_cfg.debounce_time}) begin
                        n_phase = kdc_pkg::PH_IDLE;
                        n_last  = i_scan.now;
                        // release confirmed: up, single click or double click
                        if (in_window) begin
                            if (click_inc >= kdc_pkg::CLICK_DOUBLE) begin
                                n_event = kdc_pkg::EV_DCLICK;
                                n_click = '0;
                            end else begin
                                n_event = kdc_pkg::EV_UP;
                                n_click = click_inc;
                            end
                        end else begin
                            n_event = kdc_pkg::EV_CLICK;
                            n_click = kdc_pkg::CLICK_ONE;
                        end
                    end
                end else begin
                    n_phase = kdc_pkg::PH_PRESS;
                end
            end
            kdc_pkg::PH_LONG: begin
                if (act) begin
                    n_tick = tick_inc;
                    if (tick_inc >= {1'b0, i_cfg.repeat_time}) begin
                        n_event = kdc_pkg::EV_REPEAT;
                        n_tick  = '0;
                    end
                end else begin
                    n_phase = kdc_pkg::PH_RDEB;
                    n_event = kdc_pkg::EV_LUP;
                    n_tick  = '0;
                end
            end
            default: begin
                n_phase = kdc_pkg::PH_IDLE;
            end
        endcase
    end

    // State write-back for keys in use
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < KEYS; k++) begin
                r_phase[k] <= kdc_pkg::PH_IDLE;
                r_event[k] <= kdc_pkg::EV_NONE;
                r_tick[k]  <= '0;
                r_click[k] <= '0;
                r_last[k]  <= '0;
            end
        end else if (o_scan_take && in_use) begin
            r_phase[key] <= n_phase;
            r_event[key] <= n_event;
            r_tick[key]  <= n_tick;
            r_click[key] <= n_click;
            r_last[key]  <= n_last;
        end
    end

    // Result; unused keys show the stored phase and no event
    always_comb begin
        result.key_out      = key;
        result.sample_class = i_scan.cls;
        result.key_phase    = in_use ? n_phase : cur_phase;
        result.key_event    = in_use ? n_event : kdc_pkg::EV_NONE;
    end

    kdc_fifo #(
        .WIDTH ($bits(kdc_pkg::t_out_item)),
        .DEPTH (2)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (o_scan_take),
        .i_data  (result),
        .o_full  (out_full),
        .i_pop   (i_pop),
        .o_data  (o_item),
        .o_empty (o_empty)
    );

endmodule

// ===== sv/key_debounce_click_detector.sv =====
// ----------------------------------------------------------------------------
// key_debounce_click_detector: debounced key scanner with click detection
// Top level: configuration registers, vote front end, per-key state engine.
// ----------------------------------------------------------------------------
// Push one scan of one key (five raw samples and the millisecond time) while
// full is low; one result per scan comes out in order, shown while empty is
// low and taken with pop. Scans are accepted one per clock cycle sustained
// while results are popped as fast: the vote is taken as a scan enters the
// front queue, and the per-key read-modify-write of phase, tick, event and
// click state is done while the scan sits at the head of that queue; its
// result is then registered in the result queue. Two-entry queues between
// intake and state engine and in front of the result port absorb a stall on
// either side until they fill. The latched event of a key is only overwritten
// by a later event and cleared only by reset. Keys at or above key_count keep
// their state and report no event. Registers accept a write every cycle and
// should only change while no scan is in flight.
module key_debounce_click_detector (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  kdc_pkg::t_in_item                  i_in_item,
    output logic                               empty,
    input  logic                               pop,
    output kdc_pkg::t_out_item                 o_out_item,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [kdc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [kdc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    kdc_pkg::t_cfg  r_cfg;
    kdc_pkg::t_scan scan;
    logic           scan_valid, scan_take;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scan_step       <= kdc_pkg::RST_SCAN_STEP;
            r_cfg.debounce_time   <= kdc_pkg::RST_DEBOUNCE;
            r_cfg.long_press_time <= kdc_pkg::RST_LONG_PRESS;
            r_cfg.repeat_time     <= kdc_pkg::RST_REPEAT;
            r_cfg.dc_window       <= kdc_pkg::RST_DC_WINDOW;
            r_cfg.key_count       <= kdc_pkg::RST_KEY_COUNT;
            r_cfg.level_mask      <= kdc_pkg::RST_LEVEL_MASK;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                kdc_pkg::CFG_SCAN_STEP:  r_cfg.scan_step       <= i_cfg_data[7:0];
                kdc_pkg::CFG_DEBOUNCE:   r_cfg.debounce_time   <= i_cfg_data;
                kdc_pkg::CFG_LONG_PRESS: r_cfg.long_press_time <= i_cfg_data;
                kdc_pkg::CFG_REPEAT:     r_cfg.repeat_time     <= i_cfg_data;
                kdc_pkg::CFG_DC_WINDOW:  r_cfg.dc_window       <= i_cfg_data;
                kdc_pkg::CFG_KEY_COUNT:  r_cfg.key_count       <= i_cfg_data[3:0];
                kdc_pkg::CFG_LEVEL_MASK: r_cfg.level_mask      <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    kdc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_item       (i_in_item),
        .i_level_mask (r_cfg.level_mask),
        .o_scan       (scan),
        .o_scan_valid (scan_valid),
        .i_scan_take  (scan_take)
    );

    kdc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_scan       (scan),
        .i_scan_valid (scan_valid),
        .o_scan_take  (scan_take),
        .i_cfg        (r_cfg),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_item       (o_out_item)
    );

endmodule

// ===== sv/kdc_checker.sv =====
// ----------------------------------------------------------------------------
// kdc_checker: port-level checks of the key debounce / click detector
// Watches the top level's queue ports; attached to the top level by bind.
// ----------------------------------------------------------------------------
module kdc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input kdc_pkg::t_out_item o_out_item
);

    // Both queues come out of reset drained
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not cleared by reset");

    // The engine drains intake whenever the result queue is empty
    a_not_full_and_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(full && empty))
        else $error("intake full while no result waits");

    // A waiting result holds until popped
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_item)))
        else $error("waiting result changed or vanished");

    // A key in use sits in press debounce only on a pressed vote
    a_pdeb_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_item.key_event != kdc_pkg::EV_NONE
         && o_out_item.key_phase == kdc_pkg::PH_PDEB)
        |-> (o_out_item.sample_class == kdc_pkg::CLS_PRESSED))
        else $error("press debounce without pressed vote");

endmodule

bind key_debounce_click_detector kdc_checker u_kdc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .o_out_item (o_out_item)
);

// ===== sim/key_debounce_click_detector_tb.sv =====
// ----------------------------------------------------------------------------
// key_debounce_click_detector_tb: self-checking bench for the key scanner
// Feeds scans of debounced keys through the push side while register settings
// change between phases, mirrors the per-key state engine in a local
// predictor, and compares every popped result field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module key_debounce_click_detector_tb;

    localparam int KEYS         = kdc_pkg::KEYS;
    localparam int KEY_W        = kdc_pkg::KEY_W;
    localparam int SAMPLE_COUNT = kdc_pkg::SAMPLE_COUNT;
    localparam int TICK_W       = kdc_pkg::TICK_W;
    localparam int TIME_W       = kdc_pkg::TIME_W;
    localparam int CFG_IDX_W    = kdc_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W   = kdc_pkg::CFG_DATA_W;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 100;
    localparam int DRAIN_CYCLES   = 4;
    localparam int TAIL_CYCLES    = 10;

    // Per-key state as the predictor tracks it
    typedef struct {
        logic [2:0]        phase;
        logic [2:0]        latched;
        logic [TICK_W-1:0] ticks;
        logic [1:0]        clicks;
        logic [TIME_W-1:0] last_release;
    } t_key_track;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  push        = 1'b0;
    logic                  full;
    kdc_pkg::t_in_item     i_in_item   = '0;
    logic                  empty;
    logic                  pop         = 1'b0;
    kdc_pkg::t_out_item    o_out_item;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    kdc_pkg::t_in_item  scan_backlog[$];
    kdc_pkg::t_out_item pending_reports[$];
    t_key_track         key_track[KEYS];
    kdc_pkg::t_cfg      live_regs;
    logic [TIME_W-1:0]  scan_time;
    int                 scans_planned = 0;
    int                 fail_count    = 0;
    int                 burst_left    = 0;
    int                 gap_left      = 0;
    int                 idle_cycles   = 0;
    logic [5:0]         pop_slot      = '0;
    logic [7:0]         pop_mask      = 8'hFF;

    key_debounce_click_detector DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_item   (i_in_item),
        .empty       (empty),
        .pop         (pop),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Tick count after one scan, saturating at the counter width
    function automatic logic [TICK_W-1:0] tick_after_scan(input logic [TICK_W-1:0] t);
        logic [TICK_W:0] sum;
        sum = {1'b0, t} + live_regs.scan_step;
        return (sum > kdc_pkg::TICK_MAX) ? kdc_pkg::TICK_MAX : sum[TICK_W-1:0];
    endfunction

    // Vote the samples, advance the key's state, and build its report
    function automatic kdc_pkg::t_out_item next_key_report(input kdc_pkg::t_in_item scan);
        kdc_pkg::t_out_item rep;
        logic [KEY_W-1:0]   k;
        logic               lvl;
        int                 votes;
        int                 i;
        logic [1:0]         cls;
        logic               held;
        logic [TIME_W-1:0]  since;
        k     = scan.key_select;
        lvl   = live_regs.level_mask[k];
        votes = 0;
        for (i = 0; i < SAMPLE_COUNT; i++) begin
            if (scan.pin_samples[i] == lvl) votes++;
        end
        if (votes >= int'(kdc_pkg::VOTE_PRESS))
            cls = kdc_pkg::CLS_PRESSED;
        else if (votes <= int'(kdc_pkg::VOTE_RELEASE))
            cls = kdc_pkg::CLS_RELEASED;
        else
            cls = kdc_pkg::CLS_BOUNCE;
        held             = (cls == kdc_pkg::CLS_PRESSED);
        rep.key_out      = k;
        rep.sample_class = cls;

        // unused key: state untouched, no event
        if ({1'b0, k} >= live_regs.key_count) begin
            rep.key_phase = key_track[k].phase;
            rep.key_event = kdc_pkg::EV_NONE;
            return rep;
        end

        case (key_track[k].phase)
            kdc_pkg::PH_IDLE: begin
                if (held) begin
                    key_track[k].phase = kdc_pkg::PH_PDEB;
                    key_track[k].ticks = '0;
                end
            end
            kdc_pkg::PH_PDEB: begin
                if (held) begin
                    key_track[k].ticks = tick_after_scan(key_track[k].ticks);
                    if (key_track[k].ticks >= live_regs.debounce_time) begin
                        key_track[k].phase   = kdc_pkg::PH_PRESS;
                        key_track[k].latched = kdc_pkg::EV_DOWN;
                        key_track[k].ticks   = '0;
                    end
                end else begin
                    key_track[k].phase = kdc_pkg::PH_IDLE;
                end
            end
            kdc_pkg::PH_PRESS: begin
                if (held) begin
                    key_track[k].ticks = tick_after_scan(key_track[k].ticks);
                    if (key_track[k].ticks >= live_regs.long_press_time) begin
                        key_track[k].phase   = kdc_pkg::PH_LONG;
                        key_track[k].latched = kdc_pkg::EV_LDOWN;
                        key_track[k].ticks   = '0;
                    end
                end else begin
                    key_track[k].phase = kdc_pkg::PH_RDEB;
                    key_track[k].ticks = '0;
                end
            end
            kdc_pkg::PH_RDEB: begin
                if (!held) begin
                    key_track[k].ticks = tick_after_scan(key_track[k].ticks);
                    if (key_track[k].ticks >= live_regs.debounce_time) begin
                        key_track[k].phase   = kdc_pkg::PH_IDLE;
                        key_track[k].latched = kdc_pkg::EV_UP;
                        // wrapping time since the previous confirmed release
                        since = scan.now_ms - key_track[k].last_release;
                        if (since < {16'b0, live_regs.dc_window}) begin
                            key_track[k].clicks = key_track[k].clicks + 2'd1;
                            if (key_track[k].clicks >= kdc_pkg::CLICK_DOUBLE) begin
                                key_track[k].latched = kdc_pkg::EV_DCLICK;
                                key_track[k].clicks  = '0;
                            end
                        end else begin
                            key_track[k].clicks  = kdc_pkg::CLICK_ONE;
                            key_track[k].latched = kdc_pkg::EV_CLICK;
                        end
                        key_track[k].last_release = scan.now_ms;
                    end
                end else begin
                    key_track[k].phase = kdc_pkg::PH_PRESS;
                end
            end
            kdc_pkg::PH_LONG: begin
                if (held) begin
                    key_track[k].ticks = tick_after_scan(key_track[k].ticks);
                    if (key_track[k].ticks >= live_regs.repeat_time) begin
                        key_track[k].latched = kdc_pkg::EV_REPEAT;
                        key_track[k].ticks   = '0;
                    end
                end else begin
                    key_track[k].phase   = kdc_pkg::PH_RDEB;
                    key_track[k].latched = kdc_pkg::EV_LUP;
                    key_track[k].ticks   = '0;
                end
            end
            default: key_track[k].phase = kdc_pkg::PH_IDLE;
        endcase

        rep.key_phase = key_track[k].phase;
        rep.key_event = key_track[k].latched;
        return rep;
    endfunction

    function automatic kdc_pkg::t_cfg make_settings(input int unsigned step,
                                                    input int unsigned deb,
                                                    input int unsigned lng,
                                                    input int unsigned rpt,
                                                    input int unsigned win,
                                                    input int unsigned cnt,
                                                    input int unsigned mask);
        kdc_pkg::t_cfg s;
        s.scan_step       = 8'(step);
        s.debounce_time   = 16'(deb);
        s.long_press_time = 16'(lng);
        s.repeat_time     = 16'(rpt);
        s.dc_window       = 16'(win);
        s.key_count       = 4'(cnt);
        s.level_mask      = 8'(mask);
        return s;
    endfunction

    // Thresholds a few scans long so that every event shows up often
    function automatic kdc_pkg::t_cfg random_settings();
        int unsigned step;
        step = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 30) : $urandom_range(1, 255);
        return make_settings(step,
                             step * $urandom_range(1, 4) - $urandom_range(0, step - 1),
                             step * $urandom_range(2, 10) - $urandom_range(0, step - 1),
                             step * $urandom_range(1, 4) - $urandom_range(0, step - 1),
                             $urandom_range(1, 40 * step),
                             $urandom_range(1, KEYS),
                             $urandom);
    endfunction

    function automatic int scans_to_reach(input int unsigned thr, input int unsigned step);
        int n;
        n = (thr + step - 1) / step;
        return (n < 1) ? 1 : n;
    endfunction

    // Pin samples with a vote count that lands in the wanted class
    function automatic logic [SAMPLE_COUNT-1:0] make_pins(input logic lvl,
                                                           input logic [1:0] cls);
        logic [SAMPLE_COUNT-1:0] act_bits;
        int                      n;
        int                      count;
        int                      idx;
        case (cls)
            kdc_pkg::CLS_PRESSED:  n = $urandom_range(4, 5);
            kdc_pkg::CLS_RELEASED: n = $urandom_range(0, 1);
            default:               n = $urandom_range(2, 3);
        endcase
        act_bits = '0;
        count    = 0;
        while (count < n) begin
            idx = $urandom_range(0, SAMPLE_COUNT - 1);
            if (!act_bits[idx]) begin
                act_bits[idx] = 1'b1;
                count++;
            end
        end
        return lvl ? act_bits : ~act_bits;
    endfunction

    task automatic push_scan(input logic [KEY_W-1:0] key, input logic [SAMPLE_COUNT-1:0] pins,
                             input logic [TIME_W-1:0] now);
        kdc_pkg::t_in_item s;
        s.key_select  = key;
        s.pin_samples = pins;
        s.now_ms      = now;
        scan_backlog.push_back(s);
        scans_planned++;
    endtask

    // One scan of a gesture, sometimes preceded by a stray scan
    task automatic queue_scan(input int key, input logic [SAMPLE_COUNT-1:0] pins,
                              input kdc_pkg::t_cfg cfg);
        if ($urandom_range(0, 9) == 0)
            push_scan(3'($urandom), 5'($urandom), $urandom_range(0, 1) ? scan_time : $urandom);
        push_scan(3'(key), pins, scan_time);
        scan_time += cfg.scan_step + $urandom_range(0, cfg.scan_step);
    endtask

    // Press and release gestures sized against the current thresholds
    task automatic queue_gestures(input kdc_pkg::t_cfg cfg, input int budget);
        int   goal;
        int   key;
        int   dp;
        int   lp;
        int   rp;
        int   press_len;
        int   release_len;
        int   bounce_at;
        int   mode;
        int   i;
        logic lvl;
        goal = scans_planned + budget;
        while (scans_planned < goal) begin
            if (cfg.key_count == 0 || $urandom_range(0, 9) == 0)
                key = $urandom_range(0, KEYS - 1);
            else
                key = $urandom_range(0, cfg.key_count - 1);
            lvl  = cfg.level_mask[key];
            dp   = scans_to_reach(cfg.debounce_time, cfg.scan_step);
            lp   = scans_to_reach(cfg.long_press_time, cfg.scan_step);
            rp   = scans_to_reach(cfg.repeat_time, cfg.scan_step);
            mode = $urandom_range(0, 9);
            if (mode < 2)
                press_len = 1 + $urandom_range(0, dp - 1);
            else if (mode < 7 || 1 + dp + lp + 4 * rp > 400)
                press_len = 1 + dp + $urandom_range(0, lp - 1);
            else
                press_len = 1 + dp + lp + $urandom_range(0, 3) * rp + $urandom_range(0, rp - 1);
            bounce_at = ($urandom_range(0, 11) == 0) ? $urandom_range(0, press_len - 1) : -1;
            for (i = 0; i < press_len; i++)
                queue_scan(key,
                           make_pins(lvl, (i == bounce_at) ? kdc_pkg::CLS_BOUNCE
                                                           : kdc_pkg::CLS_PRESSED),
                           cfg);
            // mostly a full release debounce, sometimes cut short
            release_len = ($urandom_range(0, 6) == 0) ? $urandom_range(1, dp) : 1 + dp;
            for (i = 0; i < release_len; i++)
                queue_scan(key, make_pins(lvl, kdc_pkg::CLS_RELEASED), cfg);
            // quiet time before the next gesture
            case ($urandom_range(0, 9))
                0:       scan_time += $urandom;
                1, 2, 3: scan_time += $urandom_range(0, 2 * cfg.dc_window);
                default: ;
            endcase
        end
    endtask

    task automatic wait_for_drain();
        while (scan_backlog.size() != 0 || push || pending_reports.size() != 0)
            @(posedge i_clk);
    endtask

    // Leaves valid high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            kdc_pkg::CFG_SCAN_STEP:  live_regs.scan_step       = data[7:0];
            kdc_pkg::CFG_DEBOUNCE:   live_regs.debounce_time   = data;
            kdc_pkg::CFG_LONG_PRESS: live_regs.long_press_time = data;
            kdc_pkg::CFG_REPEAT:     live_regs.repeat_time     = data;
            kdc_pkg::CFG_DC_WINDOW:  live_regs.dc_window       = data;
            kdc_pkg::CFG_KEY_COUNT:  live_regs.key_count       = data[3:0];
            kdc_pkg::CFG_LEVEL_MASK: live_regs.level_mask      = data[7:0];
            default: ;
        endcase
    endtask

    // Settings change only once the block has gone quiet
    task automatic program_settings(input kdc_pkg::t_cfg s);
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        write_reg(kdc_pkg::CFG_SCAN_STEP,  {8'($urandom), s.scan_step});
        write_reg(kdc_pkg::CFG_DEBOUNCE,   s.debounce_time);
        write_reg(kdc_pkg::CFG_LONG_PRESS, s.long_press_time);
        write_reg(kdc_pkg::CFG_REPEAT,     s.repeat_time);
        write_reg(kdc_pkg::CFG_DC_WINDOW,  s.dc_window);
        write_reg(kdc_pkg::CFG_KEY_COUNT,  {12'($urandom), s.key_count});
        write_reg(kdc_pkg::CFG_LEVEL_MASK, {8'($urandom), s.level_mask});
        i_cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    // Scan driver: bursts of random length with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) pending_reports.push_back(next_key_report(i_in_item));
            if (!push || !full) begin
                if (gap_left > 0) begin
                    push     <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (scan_backlog.size() != 0) begin
                    i_in_item <= scan_backlog.pop_front();
                    push      <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left <= burst_left - 1;
                    end else begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Result side: pop follows a rotating mask reloaded each time the slot counter wraps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop      <= 1'b0;
            pop_slot <= '0;
        end else begin
            pop_slot <= pop_slot + 6'd1;
            pop      <= pop_mask[pop_slot[2:0]];
            if (pop_slot == 6'd63)
                pop_mask <= ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
        end
    end

    // Compare each popped result with the oldest prediction
    always @(posedge i_clk) begin
        kdc_pkg::t_out_item want;
        if (i_rst_n && pop && !empty) begin
            if (pending_reports.size() == 0) begin
                fail_count++;
                $error("result popped with no scan outstanding: key %0d", o_out_item.key_out);
            end else begin
                want = pending_reports.pop_front();
                check_field("key_out",      32'(want.key_out),      32'(o_out_item.key_out));
                check_field("key_phase",    32'(want.key_phase),    32'(o_out_item.key_phase));
                check_field("key_event",    32'(want.key_event),    32'(o_out_item.key_event));
                check_field("sample_class", 32'(want.sample_class),
                            32'(o_out_item.sample_class));
            end
        end
    end

    // Watchdog: cycles with work outstanding but no handshake anywhere
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready) ||
            (scan_backlog.size() == 0 && !push && pending_reports.size() == 0 && !i_cfg_valid)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus sequence
    initial begin
        kdc_pkg::t_cfg s;
        int            i;
        for (i = 0; i < KEYS; i++) begin
            key_track[i].phase        = kdc_pkg::PH_IDLE;
            key_track[i].latched      = kdc_pkg::EV_NONE;
            key_track[i].ticks        = '0;
            key_track[i].clicks       = '0;
            key_track[i].last_release = '0;
        end
        live_regs = make_settings(kdc_pkg::RST_SCAN_STEP, kdc_pkg::RST_DEBOUNCE,
                                  kdc_pkg::RST_LONG_PRESS, kdc_pkg::RST_REPEAT,
                                  kdc_pkg::RST_DC_WINDOW, kdc_pkg::RST_KEY_COUNT,
                                  kdc_pkg::RST_LEVEL_MASK);
        scan_time = $urandom;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: one key in use, active low
        push_scan(3'd0, 5'b11111, 32'h0000_0000);
        push_scan(3'd0, 5'b00000, 32'hFFFF_FFFF);
        push_scan(3'd7, 5'b00000, 32'h0000_0001);
        push_scan(3'd3, 5'b10101, 32'h0000_0002);
        push_scan(3'd0, 5'b00000, 32'h0000_0003);

        // directed walk: down, long down, repeat, long up, click, double click
        // across the time wrap, bounce, a key of each active level
        program_settings(make_settings(10, 10, 20, 10, 100, KEYS, 8'hAA));
        push_scan(3'd0, 5'b00000, 32'd100);
        push_scan(3'd0, 5'b00001, 32'd110);
        push_scan(3'd0, 5'b10000, 32'd120);
        push_scan(3'd0, 5'b00000, 32'd130);
        push_scan(3'd0, 5'b00000, 32'd140);
        push_scan(3'd0, 5'b11111, 32'd150);
        push_scan(3'd0, 5'b11110, 32'hFFFF_FFF0);
        push_scan(3'd0, 5'b00011, 32'hFFFF_FFF8);
        push_scan(3'd0, 5'b00000, 32'hFFFF_FFFC);
        push_scan(3'd0, 5'b00000, 32'h0000_0000);
        push_scan(3'd0, 5'b11111, 32'h0000_0005);
        push_scan(3'd0, 5'b11111, 32'h0000_0014);
        push_scan(3'd7, 5'b11111, 32'h0000_0019);
        push_scan(3'd1, 5'b01100, 32'h0000_001E);

        // zero thresholds: reached on the first count
        s = make_settings(1, 0, 0, 0, 1, KEYS, $urandom);
        program_settings(s);
        queue_gestures(s, 60);

        repeat (3) begin
            s = random_settings();
            program_settings(s);
            queue_gestures(s, 110);
        end

        // largest step and thresholds
        s = make_settings(255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, KEYS, 8'hFF);
        program_settings(s);
        queue_gestures(s, 100);

        // smallest settings
        s = make_settings(1, 1, 1, 1, 1, KEYS, 8'h00);
        program_settings(s);
        queue_gestures(s, 60);

        // no key in use
        s = random_settings();
        s.key_count = '0;
        program_settings(s);
        queue_gestures(s, 30);

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_reports.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
